// ===== rtl/sacma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span class map allocator package
// Command codes, register indexes and fixed field widths shared by the
// allocator modules.
// ----------------------------------------------------------------------------
package sacma_pkg;

   localparam int ADDR_W  = 48;
   localparam int CLASS_W = 8;
   localparam int TAG_W   = 8;
   localparam int COUNT_W = 64;
   localparam int CMD_W   = 2;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CARVE  = 2'd0,
      CMD_ATTACH = 2'd1,
      CMD_DETACH = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_BASE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_READY = 1'd1;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [TAG_W-1:0]   tag_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage

// ===== rtl/sacma_addr_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span address decode
// Checks that a byte address is non-zero, inside the arena and span aligned,
// and gives the span index.
// ----------------------------------------------------------------------------
module sacma_addr_decode #(
   parameter int SPAN_COUNT = 1024,
   parameter int SPAN_SHIFT = 16,
   parameter int IDX_W      = 10
) (
   input  sacma_pkg::addr_type arena_base,
   input  sacma_pkg::addr_type span_address,
   output logic                hit,
   output logic [IDX_W-1:0]    span_idx
);
   import sacma_pkg::*;

   localparam addr_type ARENA_BYTES = addr_type'(SPAN_COUNT) << SPAN_SHIFT;

   addr_type offset;
   logic     nonzero;
   logic     above_base;
   logic     in_range;
   logic     aligned;

   always_comb begin
      offset     = span_address - arena_base;
      nonzero    = (span_address != '0);
      above_base = (span_address >= arena_base);
      in_range   = (offset < ARENA_BYTES);
      aligned    = (offset[SPAN_SHIFT-1:0] == '0);
      hit        = nonzero && above_base && in_range && aligned;
      span_idx   = offset[SPAN_SHIFT +: IDX_W];
   end

endmodule

// ===== rtl/sacma_tag_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span tag store
// One tag per span in a single-write, single-read memory with registered
// read data, a clearing sweep after reset and a bypass for a write that
// lands on the same edge as the read.
// ----------------------------------------------------------------------------
module sacma_tag_store #(
   parameter int SPAN_COUNT = 1024,
   parameter int IDX_W      = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_idx,
   output sacma_pkg::tag_type  rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  sacma_pkg::tag_type  wr_data,
   output logic                clearing
);
   import sacma_pkg::*;

   tag_type mem [SPAN_COUNT];

   tag_type          mem_rd_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             byp_valid_ff;
   logic [IDX_W-1:0] byp_idx_ff;
   tag_type          byp_data_ff;
   logic             clearing_ff;
   logic             clearing_in;
   logic [IDX_W-1:0] clr_idx_ff;
   logic [IDX_W-1:0] clr_idx_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_widx;
   tag_type          mem_wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == IDX_W'(SPAN_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      mem_we    = clearing_ff || wr_en;
      mem_widx  = clearing_ff ? clr_idx_ff : wr_idx;
      mem_wdata = clearing_ff ? tag_type'(0) : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
         if (rd_en) begin
            byp_valid_ff <= wr_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_widx] <= mem_wdata;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_idx];
         rd_idx_ff   <= rd_idx;
         byp_idx_ff  <= wr_idx;
         byp_data_ff <= wr_data;
      end
   end

   // take the write that landed on the read edge over the stale memory word
   assign rd_data  = (byp_valid_ff && (byp_idx_ff == rd_idx_ff)) ? byp_data_ff : mem_rd_ff;
   assign clearing = clearing_ff;

endmodule

// ===== rtl/span_class_map_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span class map allocator
// Bump allocator over a fixed arena of equal spans with a per-span class tag.
// ----------------------------------------------------------------------------
// A new command is accepted every cycle unless req_stall is high: the address
// check and the tag read happen at the input register, the tag compare and
// write-back at the result register.
// After reset the tag memory is swept to zero, during which req_stall stays
// high; configuration writes are taken at any time but must only be issued
// while no command is in flight.
module span_class_map_allocator_unit #(
   parameter int SPAN_COUNT  = 1024,
   parameter int SPAN_SHIFT  = 16,
   parameter int CLASS_COUNT = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sacma_pkg::CMD_W-1:0]          req_cmd,
   input  logic [sacma_pkg::CLASS_W-1:0]        req_class_id,
   input  sacma_pkg::addr_type                  req_span_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output sacma_pkg::addr_type                  rsp_carved_address,
   output sacma_pkg::count_type                 rsp_carved_total,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sacma_pkg::CSR_IDX_W-1:0]      csr_index,
   input  sacma_pkg::addr_type                  csr_data
);
   import sacma_pkg::*;

   localparam int IDX_W = (SPAN_COUNT > 1) ? $clog2(SPAN_COUNT) : 1;
   localparam int CNT_W = $clog2(SPAN_COUNT + 1);

   // configuration
   addr_type arena_base_ff;
   logic     arena_ready_ff;

   // input stage
   logic                s1_valid_ff;
   logic                s1_valid_in;
   cmd_type             s1_cmd_ff;
   logic [CLASS_W-1:0]  s1_class_ff;
   logic                s1_hit_ff;
   logic [IDX_W-1:0]    s1_idx_ff;

   // allocator state
   logic [CNT_W-1:0]    next_span_ff;
   logic [CNT_W-1:0]    next_span_in;
   count_type           carve_count_ff;
   count_type           carve_count_in;

   // result stage
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_ok_ff;
   logic                rsp_ok_in;
   addr_type            rsp_addr_ff;
   addr_type            rsp_addr_in;
   count_type           rsp_total_ff;

   logic                dec_hit;
   logic [IDX_W-1:0]    dec_idx;
   logic                clearing;
   logic                accept;
   logic                advance;
   logic                process;
   tag_type             cur_tag;
   tag_type             new_tag;
   logic                tag_we;
   logic [IDX_W-1:0]    tag_widx;
   tag_type             tag_wdata;

   sacma_addr_decode #(
      .SPAN_COUNT (SPAN_COUNT),
      .SPAN_SHIFT (SPAN_SHIFT),
      .IDX_W      (IDX_W)
   ) u_decode (
      .arena_base   (arena_base_ff),
      .span_address (req_span_address),
      .hit          (dec_hit),
      .span_idx     (dec_idx)
   );

   sacma_tag_store #(
      .SPAN_COUNT (SPAN_COUNT),
      .IDX_W      (IDX_W)
   ) u_tags (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_idx   (dec_idx),
      .rd_data  (cur_tag),
      .wr_en    (tag_we),
      .wr_idx   (tag_widx),
      .wr_data  (tag_wdata),
      .clearing (clearing)
   );

   // handshake
   always_comb begin
      advance     = !rsp_valid_ff || !rsp_stall;
      process     = s1_valid_ff && advance;
      req_stall   = clearing || (s1_valid_ff && !advance);
      accept      = req_valid && !req_stall;
      s1_valid_in = accept ? 1'b1 : (process ? 1'b0 : s1_valid_ff);
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_base_ff  <= '0;
         arena_ready_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ARENA_BASE:  arena_base_ff  <= csr_data;
            CSR_ARENA_READY: arena_ready_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // command execution
   always_comb begin
      new_tag        = tag_type'(s1_class_ff) + tag_type'(1);
      next_span_in   = next_span_ff;
      carve_count_in = carve_count_ff;
      rsp_ok_in      = 1'b0;
      rsp_addr_in    = '0;
      tag_we         = 1'b0;
      tag_widx       = s1_idx_ff;
      tag_wdata      = new_tag;
      if (process && arena_ready_ff) begin
         case (s1_cmd_ff)
            CMD_CARVE: begin
               if (next_span_ff < CNT_W'(SPAN_COUNT)) begin
                  tag_we         = 1'b1;
                  tag_widx       = next_span_ff[IDX_W-1:0];
                  rsp_addr_in    = arena_base_ff + (addr_type'(next_span_ff) << SPAN_SHIFT);
                  next_span_in   = next_span_ff + CNT_W'(1);
                  carve_count_in = carve_count_ff + count_type'(1);
                  rsp_ok_in      = 1'b1;
               end
            end
            CMD_ATTACH: begin
               if ((s1_class_ff < CLASS_W'(CLASS_COUNT)) && s1_hit_ff && (cur_tag == '0)) begin
                  tag_we    = 1'b1;
                  rsp_ok_in = 1'b1;
               end
            end
            CMD_DETACH: begin
               if (s1_hit_ff && (cur_tag == new_tag)) begin
                  tag_we    = 1'b1;
                  tag_wdata = '0;
                  rsp_ok_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
      rsp_valid_in = process ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         next_span_ff   <= '0;
         carve_count_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         next_span_ff   <= next_span_in;
         carve_count_ff <= carve_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= cmd_type'(req_cmd);
         s1_class_ff <= req_class_id;
         s1_hit_ff   <= dec_hit;
         s1_idx_ff   <= dec_idx;
      end
      if (process) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_addr_ff  <= rsp_addr_in;
         rsp_total_ff <= carve_count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_carved_address = rsp_addr_ff;
   assign rsp_carved_total   = rsp_total_ff;

   // checks
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      next_span_ff <= CNT_W'(SPAN_COUNT))
      else $error("bump cursor ran past the arena");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (carve_count_ff == $past(carve_count_ff)) ||
                 (carve_count_ff == $past(carve_count_ff) + count_type'(1)))
      else $error("carve count moved by more than one");

   a_cursor_with_count: assert property (@(posedge clock) disable iff (reset)
      !reset |=> ((next_span_ff != $past(next_span_ff)) ==
                  (carve_count_ff != $past(carve_count_ff))))
      else $error("cursor and carve count out of step");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_carved_address == '0)
      else $error("failed transaction carries an address");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !accept && !s1_valid_ff)
      else $error("transaction taken during tag sweep");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span class map allocator testbench
// Drives carve, attach and detach transactions through the allocator under
// bursty request traffic and a shifting response stall pattern. Every
// response is compared against a scripted result or an in-bench model of the
// span tag map, bump cursor and carve counter, over several arena base and ready settings.
// ----------------------------------------------------------------------------
module tb;
   import sacma_pkg::*;

   localparam int SPAN_COUNT  = 1024;
   localparam int SPAN_SHIFT  = 16;
   localparam int CLASS_COUNT = 64;
   localparam logic [63:0] SPAN_BYTES  = 64'd1 << SPAN_SHIFT;
   localparam logic [63:0] ARENA_BYTES = 64'(SPAN_COUNT) << SPAN_SHIFT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic      ok;
      addr_type  caddr;
      count_type total;
   } alloc_result_type;

   // One directed transaction; cfg rewrites the arena registers first.
   typedef struct packed {
      logic              cfg;
      addr_type          base;
      logic              rdy;
      cmd_type           op;
      logic [CLASS_W-1:0] cls;
      addr_type          addr;
      logic              typed;
      logic              ok;
      addr_type          caddr;
      count_type         total;
   } dir_row_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY
   } stall_style_type;

   localparam dir_row_type SCRIPT [0:24] = '{
      '{1'b1, 48'h0, 1'b0, CMD_CARVE,  8'd0,   48'h0,         1'b1, 1'b0, 48'h0, 64'd0},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd0,   48'h1_0000,    1'b1, 1'b0, 48'h0, 64'd0},
      '{1'b0, 48'h0, 1'b0, CMD_DETACH, 8'd0,   48'h1_0000,    1'b1, 1'b0, 48'h0, 64'd0},
      '{1'b1, 48'h0, 1'b1, CMD_CARVE,  8'd0,   48'h0,         1'b1, 1'b1, 48'h0, 64'd1},
      '{1'b0, 48'h0, 1'b0, CMD_CARVE,  8'd255, 48'h0,         1'b1, 1'b1, 48'h1_0000, 64'd2},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd5,   48'h1_0000,    1'b1, 1'b1, 48'h0, 64'd2},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd5,   48'h1_0000,    1'b1, 1'b0, 48'h0, 64'd2},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd64,  48'h2_0000,    1'b1, 1'b0, 48'h0, 64'd2},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd63,  48'h2_0000,    1'b0, 1'b0, 48'h0, 64'd0},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd1,   48'h0,         1'b1, 1'b0, 48'h0, 64'd2},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd1,   48'h2_0001,    1'b1, 1'b0, 48'h0, 64'd2},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd1,   48'h400_0000,  1'b1, 1'b0, 48'h0, 64'd2},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd0,   48'h3FF_0000,  1'b0, 1'b0, 48'h0, 64'd0},
      '{1'b0, 48'h0, 1'b0, CMD_DETACH, 8'd4,   48'h1_0000,    1'b1, 1'b0, 48'h0, 64'd2},
      '{1'b0, 48'h0, 1'b0, CMD_DETACH, 8'd5,   48'h1_0000,    1'b1, 1'b1, 48'h0, 64'd2},
      '{1'b0, 48'h0, 1'b0, CMD_DETACH, 8'd255, 48'h3_0000,    1'b0, 1'b0, 48'h0, 64'd0},
      '{1'b0, 48'h0, 1'b0, CMD_NONE,   8'd255, 48'hFFFF_FFFF_FFFF,
        1'b1, 1'b0, 48'h0, 64'd2},
      '{1'b0, 48'h0, 1'b0, CMD_DETACH, 8'd255, 48'h0,         1'b1, 1'b0, 48'h0, 64'd2},
      '{1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, CMD_CARVE, 8'd0, 48'h0,
        1'b1, 1'b1, 48'h1_FFFF, 64'd3},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd0,   48'hFFFF_FFFF_FFFF,
        1'b0, 1'b0, 48'h0, 64'd0},
      '{1'b0, 48'h0, 1'b0, CMD_DETACH, 8'd0,   48'hFFFF_FFFF_FFFF,
        1'b0, 1'b0, 48'h0, 64'd0},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd0,   48'h1_0000,    1'b1, 1'b0, 48'h0, 64'd3},
      '{1'b1, 48'h123_4000, 1'b1, CMD_ATTACH, 8'd10, 48'h128_4000,
        1'b0, 1'b0, 48'h0, 64'd0},
      '{1'b0, 48'h0, 1'b0, CMD_DETACH, 8'd10,  48'h128_4000,  1'b0, 1'b0, 48'h0, 64'd0},
      '{1'b0, 48'h0, 1'b0, CMD_ATTACH, 8'd10,  48'h128_C000,  1'b1, 1'b0, 48'h0, 64'd3}
   };

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CMD_W-1:0]   req_cmd = '0;
   logic [CLASS_W-1:0] req_class_id = '0;
   addr_type           req_span_address = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_ok;
   addr_type           rsp_carved_address;
   count_type          rsp_carved_total;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   addr_type           csr_data = '0;

   // model of the allocator state
   logic [TAG_W-1:0] span_tag [SPAN_COUNT];
   int unsigned      next_free = 0;
   count_type        carved_so_far = '0;
   addr_type         map_base = '0;
   logic             map_ready = 1'b0;

   alloc_result_type alloc_outcomes [$];
   int unsigned      mismatches = 0;
   int unsigned      cycles = 0;
   int unsigned      burst_left = 0;
   stall_style_type  stall_mode = STALL_NONE;
   int unsigned      stall_left = 0;

   span_class_map_allocator_unit #(
      .SPAN_COUNT  (SPAN_COUNT),
      .SPAN_SHIFT  (SPAN_SHIFT),
      .CLASS_COUNT (CLASS_COUNT)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_class_id       (req_class_id),
      .req_span_address   (req_span_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_carved_address (rsp_carved_address),
      .rsp_carved_total   (rsp_carved_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < SPAN_COUNT; i++) span_tag[i] = '0;
   end

   // Apply one command to the tag map, cursor and counter.
   function automatic alloc_result_type run_alloc_cmd(cmd_type op,
                                                      logic [CLASS_W-1:0] cls,
                                                      addr_type addr);
      alloc_result_type r;
      logic [TAG_W-1:0] tag;
      logic [63:0] off;
      logic hit;
      int unsigned idx;
      tag = cls + 8'd1;
      r.ok = 1'b0;
      r.caddr = '0;
      off = {16'h0, addr} - {16'h0, map_base};
      hit = addr != '0 && addr >= map_base && off < ARENA_BYTES
            && (off & (SPAN_BYTES - 64'd1)) == 64'd0;
      idx = hit ? int'(off >> SPAN_SHIFT) : 0;
      if (map_ready) begin
         case (op)
            CMD_CARVE: begin
               if (next_free < SPAN_COUNT) begin
                  r.caddr = addr_type'({16'h0, map_base} + (64'(next_free) << SPAN_SHIFT));
                  span_tag[next_free] = tag;
                  next_free++;
                  carved_so_far++;
                  r.ok = 1'b1;
               end
            end
            CMD_ATTACH: begin
               if (cls < CLASS_COUNT && hit && span_tag[idx] == '0) begin
                  span_tag[idx] = tag;
                  r.ok = 1'b1;
               end
            end
            CMD_DETACH: begin
               if (hit && span_tag[idx] == tag) begin
                  span_tag[idx] = '0;
                  r.ok = 1'b1;
               end
            end
            default: ;
         endcase
      end
      r.total = carved_so_far;
      return r;
   endfunction

   task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
   endtask

   // Send one transaction; the sender idles in gaps between bursts.
   task automatic issue(cmd_type op, logic [CLASS_W-1:0] cls, addr_type addr,
                        logic typed, alloc_result_type fixed);
      int unsigned gap;
      alloc_result_type r;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 16);
         gap = $urandom_range(0, 5);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= op;
      req_class_id <= cls;
      req_span_address <= addr;
      do @(posedge clock); while (req_stall !== 1'b0);
      r = run_alloc_cmd(op, cls, addr);
      alloc_outcomes.push_back(typed ? fixed : r);
   endtask

   // Hold off the sender until every outstanding response is back.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (alloc_outcomes.size() != 0);
   endtask

   task automatic set_arena(addr_type base, addr_type ready_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_ARENA_BASE;
      csr_data <= base;
      do @(posedge clock); while (csr_ready !== 1'b1);
      map_base = base;
      csr_index <= CSR_ARENA_READY;
      csr_data <= ready_word;
      do @(posedge clock); while (csr_ready !== 1'b1);
      map_ready = ready_word[0];
      csr_valid <= 1'b0;
   endtask

   // Response stall: switch to a randomly chosen style whenever the run of the current one ends.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_style_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 30);
         STALL_PERIODIC: rsp_stall <= (stall_left % 4 == 0);
         default:        rsp_stall <= ($urandom_range(0, 99) < 75);
      endcase
   end

   always @(posedge clock) begin : watch
      alloc_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (alloc_outcomes.size() == 0) begin
            note_mismatch("unexpected response", {63'h0, rsp_ok}, 64'h0);
         end else begin
            want = alloc_outcomes.pop_front();
            if (rsp_ok !== want.ok)
               note_mismatch("ok", {63'h0, rsp_ok}, {63'h0, want.ok});
            if (rsp_carved_address !== want.caddr)
               note_mismatch("carved_address", {16'h0, rsp_carved_address},
                             {16'h0, want.caddr});
            if (rsp_carved_total !== want.total)
               note_mismatch("carved_total", rsp_carved_total, want.total);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      dir_row_type row;
      cmd_type op;
      logic [CLASS_W-1:0] cls;
      addr_type addr;
      addr_type base_pick;
      logic [63:0] rnd;
      int unsigned pick;
      int unsigned idx;
      int unsigned phase;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 25; i++) begin
         row = SCRIPT[i];
         if (row.cfg) begin
            settle();
            set_arena(row.base, {47'h0, row.rdy});
         end
         issue(row.op, row.cls, row.addr, row.typed, '{row.ok, row.caddr, row.total});
      end

      // Mix carves with attach and detach over a spread of arena bases.
      phase = 0;
      while (phase < 6) begin
         settle();
         rnd = {$urandom, $urandom};
         case (phase % 6)
            0: base_pick = '0;
            1: base_pick = rnd[47:0];
            2: base_pick = 48'hFFFF_FF00_0000;
            3: base_pick = '1;
            4: base_pick = {24'h0, rnd[7:0], 16'h0};
            default: base_pick = {20'h0, rnd[27:0]};
         endcase
         rnd = {$urandom, $urandom};
         set_arena(base_pick, {rnd[47:1], logic'(phase % 7 != 2)});
         for (int n = 0; n < 130; n++) begin
            pick = $urandom_range(0, 99);
            idx = $urandom_range(0, SPAN_COUNT - 1);
            rnd = {$urandom, $urandom};
            if (pick < ((next_free < SPAN_COUNT) ? 60 : 15)) begin
               op = CMD_CARVE;
               cls = ($urandom_range(0, 4) == 0) ? rnd[7:0]
                                                 : CLASS_W'($urandom_range(0, CLASS_COUNT - 1));
               addr = rnd[55:8];
            end else begin
               pick = $urandom_range(0, 99);
               addr = map_base + (addr_type'(idx) << SPAN_SHIFT);
               if (pick < 40) begin
                  op = CMD_ATTACH;
                  cls = ($urandom_range(0, 6) == 0) ? rnd[7:0]
                                                    : CLASS_W'($urandom_range(0, CLASS_COUNT - 1));
               end else if (pick < 80) begin
                  op = CMD_DETACH;
                  cls = ($urandom_range(0, 3) == 0) ? rnd[7:0] : span_tag[idx] - 8'd1;
               end else if (pick < 85) begin
                  op = CMD_NONE;
                  cls = rnd[7:0];
               end else begin
                  op = cmd_type'(rnd[57:56]);
                  cls = rnd[7:0];
                  addr = rnd[55:8];
               end
               // knock the address off span alignment now and then
               if ($urandom_range(0, 19) == 0)
                  addr = addr ^ (48'h1 << $urandom_range(0, SPAN_SHIFT - 1));
            end
            if ($urandom_range(0, 49) == 0)
               settle();
            issue(op, cls, addr, 1'b0, '0);
         end
         phase++;
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sacma_pkg.sv
rtl/sacma_addr_decode.sv
rtl/sacma_tag_store.sv
rtl/span_class_map_allocator_unit.sv
test/tb.sv
